>>> sv/b64sc_pkg.sv
`default_nettype none
package b64sc_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int         MAX_RES  = 4;

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_END     = 2'd3
  } status_t;

  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  fill;
    logic [1:0]  pad;
    logic        err;
  } group_t;

  typedef struct packed {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } result_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] alphabet(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      return 8'(8'h41 + v8);
    end else if (v < 6'd52) begin
      return 8'(8'h61 + v8 - 8'd26);
    end else if (v < 6'd62) begin
      return 8'(8'h30 + v8 - 8'd52);
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  // {valid, value} of a character
  function automatic logic [6:0] char_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      return {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      return {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      return {1'b1, 6'd63};
    end else begin
      return 7'd0;
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/b64sc_step.sv
`default_nettype none
module b64sc_step (
  input  wire logic                direction,
  input  wire logic [7:0]          in_byte,
  input  wire logic                end_of_message,
  input  wire b64sc_pkg::group_t   cur,
  output b64sc_pkg::group_t        nxt,
  output b64sc_pkg::result_t [3:0] res,
  output logic [2:0]               count
);
  import b64sc_pkg::*;

  logic [23:0] enc_bits;
  logic [23:0] dec_bits;
  logic [2:0]  chars;
  logic [6:0]  cv;
  logic        is_pad;
  logic        bad;
  logic [1:0]  pad_new;
  logic [2:0]  nbytes;

  assign cv     = char_value(in_byte);
  assign is_pad = (in_byte == PAD_CHAR);
  assign bad    = (!cv[6] && !is_pad) || (is_pad && cur.fill < 2'd2) ||
                  (cv[6] && cur.pad != 2'd0);
  assign pad_new = is_pad ? 2'(cur.pad + 2'd1) : cur.pad;
  assign chars   = 3'({1'b0, cur.fill} + 3'd2);
  assign nbytes  = (pad_new >= 2'd2) ? 3'd1 : ((pad_new == 2'd1) ? 3'd2 : 3'd3);

  always_comb begin
    case (cur.fill)
      2'd0:    enc_bits = cur.bits | {in_byte, 16'h0000};
      2'd1:    enc_bits = cur.bits | {8'h00, in_byte, 8'h00};
      default: enc_bits = cur.bits | {16'h0000, in_byte};
    endcase
  end

  always_comb begin
    unique case (cur.fill)
      2'd0: dec_bits = cur.bits | {cv[5:0], 18'd0};
      2'd1: dec_bits = cur.bits | {6'd0, cv[5:0], 12'd0};
      2'd2: dec_bits = cur.bits | {12'd0, cv[5:0], 6'd0};
      2'd3: dec_bits = cur.bits | {18'd0, cv[5:0]};
    endcase
    if (is_pad) begin
      dec_bits = cur.bits;
    end
  end

  always_comb begin
    nxt   = cur;
    count = 3'd0;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '{data: 8'h00, status: ST_DATA, last: 1'b0};
    end
    if (!direction) begin
      if (cur.fill < 2'd2 && !end_of_message) begin
        nxt.bits = enc_bits;
        nxt.fill = 2'(cur.fill + 2'd1);
      end else begin
        for (int k = 0; k < MAX_RES; k++) begin
          res[k].data = (3'(k) < chars) ? alphabet(enc_bits[23-6*k -: 6]) : PAD_CHAR;
          res[k].last = end_of_message && (k == MAX_RES - 1);
        end
        count = 3'd4;
        if (end_of_message) begin
          nxt = '0;
        end else begin
          nxt.bits = '0;
          nxt.fill = 2'd0;
        end
      end
    end else begin
      priority if (cur.err) begin
        if (end_of_message) begin
          res[0] = '{data: 8'h00, status: ST_END, last: 1'b1};
          count  = 3'd1;
          nxt    = '0;
        end
      end else if (bad) begin
        res[0] = '{data: 8'h00, status: ST_INVALID, last: end_of_message};
        count  = 3'd1;
        if (end_of_message) begin
          nxt = '0;
        end else begin
          nxt.err = 1'b1;
        end
      end else if (cur.fill < 2'd3) begin
        if (end_of_message) begin
          res[0] = '{data: 8'h00, status: ST_TRUNC, last: 1'b1};
          count  = 3'd1;
          nxt    = '0;
        end else begin
          nxt.bits = dec_bits;
          nxt.pad  = pad_new;
          nxt.fill = 2'(cur.fill + 2'd1);
        end
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (3'(k) < nbytes) begin
            res[k].data = dec_bits[23-8*k -: 8];
            res[k].last = end_of_message && (3'(k + 1) == nbytes);
          end
        end
        count = nbytes;
        if (end_of_message) begin
          nxt = '0;
        end else begin
          // pad count is kept: nothing may follow a padded group
          nxt.bits = '0;
          nxt.fill = 2'd0;
          nxt.pad  = pad_new;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/base64_stream_codec_core.sv
`default_nettype none
// Base64 (standard alphabet, '=' padding) stream codec. Register 0 bit 0 picks
// the direction: 0 encodes bytes to text, 1 decodes text to bytes; writing it
// also starts a new message. Each input request is processed in the cycle it
// is accepted and its results (four characters per encode group, up to three
// bytes per decode group, or one status result) are queued in a four-entry
// result bank that drains one per cycle while out_stall is low. A request that
// produces no result does not stall the input; one that produces results holds
// the input until its last result leaves, the next request being taken in the
// cycle that last result leaves. Encoding three bytes thus queues nothing for
// the first two bytes and four characters for the third.
module base64_stream_codec_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [1:0]       status,
  output logic             last_of_run
);
  import b64sc_pkg::*;

  logic                direction;
  group_t              grp;
  group_t              grp_next;
  result_t [3:0]       step_res;
  logic [2:0]          step_count;
  result_t             bank [MAX_RES];
  logic [2:0]          pending;
  logic [1:0]          rd;
  logic                cfg_wr;
  logic                in_acc;
  logic                out_take;

  b64sc_step u_step (
    .direction      (direction),
    .in_byte        (in_byte),
    .end_of_message (end_of_message),
    .cur            (grp),
    .nxt            (grp_next),
    .res            (step_res),
    .count          (step_count)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, direction} : 32'd0;

  assign out_valid   = (pending != 3'd0);
  assign out_take    = out_valid && !out_stall;
  assign in_stall    = !((pending == 3'd0) || (pending == 3'd1 && !out_stall));
  assign in_acc      = in_valid && !in_stall;
  assign out_byte    = bank[rd].data;
  assign status      = bank[rd].status;
  assign last_of_run = bank[rd].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      grp       <= '0;
    end else if (cfg_wr) begin
      direction <= pwdata[0];
      grp       <= '0;
    end else if (in_acc) begin
      grp <= grp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
      rd      <= 2'd0;
    end else if (in_acc) begin
      pending <= step_count;
      rd      <= 2'd0;
    end else if (out_take) begin
      pending <= 3'(pending - 3'd1);
      rd      <= 2'(rd + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < MAX_RES; k++) begin
        bank[k] <= step_res[k];
      end
    end
  end

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("result bank over-full");

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> pending == 3'd1)
    else $error("last_of_run on a result that is not the final one queued");

  a_nondata_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DATA |-> out_byte == 8'h00)
    else $error("status result carries a nonzero byte");

  a_enc_fill: assert property (@(posedge clk) disable iff (rst)
    !direction |-> grp.fill != 2'd3 && grp.err == 1'b0)
    else $error("encoder group state out of range");

endmodule
`default_nettype wire
